// File: src/fsp_pkg.sv
// Shared types and codes for the floppy stepper and FM track port.
package fsp_pkg;

  localparam logic [1:0] CMD_PORT_READ  = 2'd0;
  localparam logic [1:0] CMD_PORT_WRITE = 2'd1;
  localparam logic [1:0] CMD_LOAD       = 2'd2;
  localparam logic [1:0] CMD_FETCH      = 2'd3;

  localparam logic [1:0] PORT_LATCH   = 2'd0;
  localparam logic [1:0] PORT_DATA    = 2'd1;
  localparam logic [1:0] PORT_POLL    = 2'd2;
  localparam logic [1:0] PORT_PROTECT = 2'd3;

  localparam logic CFG_PROTECT_MASK  = 1'b0;
  localparam logic CFG_DRIVE_PRESENT = 1'b1;

  // Item classes decided by the front end.
  localparam logic [2:0] CL_NOP     = 3'd0;
  localparam logic [2:0] CL_LATCH   = 3'd1;
  localparam logic [2:0] CL_RD_DATA = 3'd2;
  localparam logic [2:0] CL_RD_POLL = 3'd3;
  localparam logic [2:0] CL_RD_PROT = 3'd4;
  localparam logic [2:0] CL_RD_FF   = 3'd5;
  localparam logic [2:0] CL_LOAD    = 3'd6;
  localparam logic [2:0] CL_FETCH   = 3'd7;

  localparam int OUTQ_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  cls;
    logic [7:0]  write_byte;
    logic [11:0] buffer_index;
  } op_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        load_request;
    logic        flush_request;
    logic        request_drive;
    logic [5:0]  request_track;
    logic [11:0] flush_start;
    logic [11:0] flush_count;
  } result_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } ctl_t;

endpackage

// File: src/fsp_if.sv
// Valid/ready channel interfaces for requests and results.
interface fsp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  port;
  logic [7:0]  write_byte;
  logic [11:0] buffer_index;
  modport source (output valid, command, port, write_byte, buffer_index, input ready);
  modport sink (input valid, command, port, write_byte, buffer_index, output ready);
endinterface

interface fsp_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        load_request;
  logic        flush_request;
  logic        request_drive;
  logic [5:0]  request_track;
  logic [11:0] flush_start;
  logic [11:0] flush_count;
  modport source (output valid, read_data, load_request, flush_request, request_drive,
                  request_track, flush_start, flush_count, input ready);
  modport sink (input valid, read_data, load_request, flush_request, request_drive,
                request_track, flush_start, flush_count, output ready);
endinterface

// File: src/fsp_front.sv
// Front end: accept items, classify them, hold them in a two-entry queue.
module fsp_front
  import fsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fsp_req_if.sink     req,
  input  ctl_t        ctl,
  output op_t         op,
  output logic        op_valid
);

  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  op_t        cls_op;
  logic       push;

  assign req.ready = (count != 2'd2) && !ctl.busy;
  assign push      = req.valid && req.ready;
  assign op        = q[rd_ptr];
  assign op_valid  = (count != 2'd0);

  always_comb begin
    cls_op.write_byte   = req.write_byte;
    cls_op.buffer_index = req.buffer_index;
    case (req.command)
      CMD_PORT_READ: begin
        case (req.port)
          PORT_DATA:    cls_op.cls = CL_RD_DATA;
          PORT_POLL:    cls_op.cls = CL_RD_POLL;
          PORT_PROTECT: cls_op.cls = CL_RD_PROT;
          default:      cls_op.cls = CL_RD_FF;
        endcase
      end
      CMD_PORT_WRITE: cls_op.cls = (req.port == PORT_LATCH) ? CL_LATCH : CL_NOP;
      CMD_LOAD:       cls_op.cls = CL_LOAD;
      default:        cls_op.cls = CL_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls_op;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (ctl.pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, ctl.pop};
    end
  end

endmodule

// File: src/fsp_exec.sv
// Back end: drive state, stepper, FM cell decoder and the track buffer.
module fsp_exec
  import fsp_pkg::*;
#(
  parameter int TRACK_BYTES    = 3172,
  parameter int MAX_HALF_TRACK = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  input  op_t         op,
  input  logic        op_valid,
  input  logic [2:0]  out_count,
  output ctl_t        ctl,
  output logic        push,
  output result_t     push_data
);

  logic [7:0]  mem [TRACK_BYTES];
  logic [7:0]  mem_q;
  logic        mem_we;
  logic [11:0] mem_wa;
  logic [7:0]  mem_wd;
  logic        mem_re;
  logic [11:0] mem_ra;

  logic        clearing;
  logic [11:0] clr_addr;

  logic [1:0]  protect_mask;
  logic [1:0]  drive_present;

  logic              sel_valid, sel_valid_next;
  logic              sel_drive, sel_drive_next;
  logic [6:0]        half_track [2];
  logic [6:0]        half_track_next [2];
  logic              poll_ready, poll_ready_next;
  logic [15:0]       shift_word, shift_word_next, sw_cur;
  logic              sw_pend, sw_pend_next;
  logic              cell_phase, cell_phase_next;
  logic signed [4:0] bit_count, bit_count_next;
  logic [11:0]       buffer_position, buffer_position_next;
  logic [11:0]       write_start, write_start_next;
  logic [11:0]       write_count, write_count_next;
  logic [7:0]        last_latch, last_latch_next;

  logic        r1_valid;
  logic        r1_fetch;
  result_t     r1;
  result_t     res;
  logic        res_fetch;
  logic        pop;

  logic        nv, nd;
  logic [6:0]  ht_v;
  logic [1:0]  p;
  logic        p_ok;
  logic [1:0]  outb, inb;
  logic        stepped;
  logic [7:0]  d;
  logic [7:0]  val;
  logic [11:0] last_pos;

  assign last_pos = 12'(TRACK_BYTES - 1);
  assign pop      = op_valid && !clearing && ({1'b0, out_count} + {3'b0, r1_valid} < 4'(OUTQ_DEPTH));
  assign ctl.pop  = pop;
  assign ctl.busy = clearing;
  assign sw_cur   = sw_pend ? {8'h00, mem_q} : shift_word;
  assign d        = op.write_byte;

  always_comb begin
    sel_valid_next       = sel_valid;
    sel_drive_next       = sel_drive;
    half_track_next[0]   = half_track[0];
    half_track_next[1]   = half_track[1];
    poll_ready_next      = poll_ready;
    shift_word_next      = sw_cur;
    sw_pend_next         = 1'b0;
    cell_phase_next      = cell_phase;
    bit_count_next       = bit_count;
    buffer_position_next = buffer_position;
    write_start_next     = write_start;
    write_count_next     = write_count;
    last_latch_next      = last_latch;
    mem_we  = 1'b0;
    mem_wa  = clr_addr;
    mem_wd  = 8'h00;
    mem_re  = 1'b0;
    mem_ra  = buffer_position;
    res     = '0;
    res.read_data = 8'hff;
    res_fetch = 1'b0;
    nv = d[4] | d[7];
    nd = ~d[4];
    ht_v = half_track[nd];
    p = 2'd0;
    p_ok = 1'b0;
    outb = 2'd0;
    inb = 2'd0;
    stepped = 1'b0;
    val = 8'h00;

    if (clearing) begin
      mem_we = 1'b1;
    end else if (pop) begin
      case (op.cls)
        CL_RD_DATA: begin
          if (bit_count > 5'sd0) begin
            if (poll_ready) bit_count_next = bit_count - 5'sd1;
            res.read_data = 8'(sw_cur >> bit_count_next[3:0]);
          end
          if (bit_count_next == 5'sd0) begin
            // Refill the shift word from the buffer; it lands next cycle.
            mem_re = 1'b1;
            mem_ra = buffer_position;
            sw_pend_next = 1'b1;
            if (poll_ready) begin
              bit_count_next = 5'sd8;
              buffer_position_next = (buffer_position == last_pos) ? 12'd0
                                                                   : buffer_position + 12'd1;
            end
            poll_ready_next = 1'b0;
          end
        end
        CL_RD_POLL: begin
          if (sel_valid) poll_ready_next = 1'b1;
          res.read_data = poll_ready_next ? 8'h80 : 8'h00;
        end
        CL_RD_PROT: begin
          if (sel_valid) res.read_data = protect_mask[sel_drive] ? 8'h80 : 8'h00;
        end
        CL_LOAD: begin
          if (op.buffer_index < 12'(TRACK_BYTES)) begin
            mem_we = 1'b1;
            mem_wa = op.buffer_index;
            mem_wd = d;
          end
        end
        CL_FETCH: begin
          if (op.buffer_index < 12'(TRACK_BYTES)) begin
            mem_re = 1'b1;
            mem_ra = op.buffer_index;
            res_fetch = 1'b1;
          end
        end
        CL_LATCH: begin
          // Selecting a drive that is present requests a load of its current track.
          if ((nv != sel_valid) || (nv && (nd != sel_drive))) begin
            sel_valid_next = nv;
            sel_drive_next = nd;
            if (nv) begin
              buffer_position_next = 12'd0;
              write_count_next = 12'd0;
              if (drive_present[nd]) begin
                res.load_request = 1'b1;
                res.request_drive = nd;
                res.request_track = ht_v[6:1];
              end
            end
          end
          if (nv) begin
            case (d[3:0])
              4'b0001: begin p = 2'd0; p_ok = 1'b1; end
              4'b0010: begin p = 2'd1; p_ok = 1'b1; end
              4'b0100: begin p = 2'd2; p_ok = 1'b1; end
              4'b1000: begin p = 2'd3; p_ok = 1'b1; end
              default: begin p = 2'd0; p_ok = 1'b0; end
            endcase
            outb = p + 2'd1;
            inb  = p + 2'd3;
            if (p_ok) begin
              if (last_latch[outb]) begin
                stepped = 1'b1;
                if (ht_v != 7'd0) ht_v = ht_v - 7'd1;
              end else if (last_latch[inb]) begin
                stepped = 1'b1;
                if (ht_v < 7'(MAX_HALF_TRACK)) ht_v = ht_v + 7'd1;
              end
            end
            if (stepped && !ht_v[0]) begin
              buffer_position_next = 12'd0;
              write_count_next = 12'd0;
              if (drive_present[nd]) begin
                res.load_request = 1'b1;
                res.request_drive = nd;
                res.request_track = ht_v[6:1];
              end
            end
            half_track_next[nd] = ht_v;

            if (!d[6]) begin
              shift_word_next = {sw_cur[14:0], last_latch[5] ^ d[5]};
              cell_phase_next = ~cell_phase;
              if (!cell_phase_next) begin
                if (bit_count >= 5'sd0) bit_count_next = bit_count - 5'sd1;
                if (bit_count_next == 5'sd0) begin
                  for (int i = 0; i < 8; i++) val[i] = shift_word_next[2 * i];
                  mem_we = 1'b1;
                  mem_wa = buffer_position_next;
                  mem_wd = val;
                  buffer_position_next = (buffer_position_next == last_pos) ? 12'd0
                                       : buffer_position_next + 12'd1;
                  if (write_count_next != 12'hfff) write_count_next = write_count_next + 12'd1;
                  bit_count_next = 5'sd8;
                end
              end
            end

            if (last_latch[6] ^ d[6]) begin
              if (last_latch[6]) begin
                write_start_next = buffer_position_next;
                cell_phase_next = 1'b0;
              end else if ((write_count_next != 12'd0) && drive_present[nd]) begin
                res.load_request  = 1'b0;
                res.flush_request = 1'b1;
                res.request_drive = nd;
                res.request_track = ht_v[6:1];
                res.flush_start   = write_start;
                res.flush_count   = write_count_next;
              end
              bit_count_next = 5'sd8;
              write_count_next = 12'd0;
            end
          end
          last_latch_next = d;
        end
        default: begin
          res.read_data = 8'hff;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r1 <= res;
      r1_fetch <= res_fetch;
    end
    if (rst) begin
      clearing      <= 1'b1;
      clr_addr      <= 12'd0;
      protect_mask  <= 2'd3;
      drive_present <= 2'd0;
      sel_valid     <= 1'b0;
      sel_drive     <= 1'b0;
      half_track[0] <= 7'(MAX_HALF_TRACK);
      half_track[1] <= 7'(MAX_HALF_TRACK);
      poll_ready    <= 1'b0;
      shift_word    <= 16'd0;
      sw_pend       <= 1'b0;
      cell_phase    <= 1'b0;
      bit_count     <= 5'sd8;
      buffer_position <= 12'd0;
      write_start   <= 12'd0;
      write_count   <= 12'd0;
      last_latch    <= 8'd0;
      r1_valid      <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 12'd1;
        if (clr_addr == last_pos) clearing <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROTECT_MASK:  protect_mask <= cfg_data;
          CFG_DRIVE_PRESENT: drive_present <= cfg_data;
          default:           protect_mask <= protect_mask;
        endcase
      end
      sel_valid     <= sel_valid_next;
      sel_drive     <= sel_drive_next;
      half_track[0] <= half_track_next[0];
      half_track[1] <= half_track_next[1];
      poll_ready    <= poll_ready_next;
      shift_word    <= shift_word_next;
      sw_pend       <= sw_pend_next;
      cell_phase    <= cell_phase_next;
      bit_count     <= bit_count_next;
      buffer_position <= buffer_position_next;
      write_start   <= write_start_next;
      write_count   <= write_count_next;
      last_latch    <= last_latch_next;
      r1_valid      <= pop;
    end
  end

  always_comb begin
    push_data = r1;
    if (r1_fetch) push_data.read_data = mem_q;
  end
  assign push = r1_valid;

endmodule

// File: src/fsp_outq.sv
// Result queue: holds finished items until the sink takes them.
module fsp_outq
  import fsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  result_t     push_data,
  output logic [2:0]  count,
  fsp_rsp_if.source   rsp
);

  result_t    q [OUTQ_DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       pop;
  result_t    head;

  assign head  = q[rd_ptr];
  assign pop   = rsp.valid && rsp.ready;
  assign rsp.valid         = (count != 3'd0);
  assign rsp.read_data     = head.read_data;
  assign rsp.load_request  = head.load_request;
  assign rsp.flush_request = head.flush_request;
  assign rsp.request_drive = head.request_drive;
  assign rsp.request_track = head.request_track;
  assign rsp.flush_start   = head.flush_start;
  assign rsp.flush_count   = head.flush_count;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

// File: src/floppy_stepper_and_fm_track_port.sv
// Top level of the two-drive floppy stepper port with FM track buffer.
// One item is taken per clock once the part is running and the result side
// keeps up; each item yields exactly one result, which passes the front queue,
// the result register and the result queue before it is offered on rsp. After
// reset the track buffer is cleared one byte per cycle, with ready held low on
// req until all TRACK_BYTES bytes (3172 by default) are cleared; configuration
// writes are taken during that pass. Latch writes select the drive, step the
// head by half tracks and, with the write gate low, decode FM cells into buffer
// bytes; data, poll and protect reads come back on read_data. Load and flush
// requests tell the host which track to fill or store.
module floppy_stepper_and_fm_track_port
  import fsp_pkg::*;
#(
  parameter int TRACK_BYTES    = 3172,
  parameter int MAX_HALF_TRACK = 80
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data,
  fsp_req_if.sink    req,
  fsp_rsp_if.source  rsp
);

  ctl_t       ctl;
  op_t        op;
  logic       op_valid;
  logic [2:0] out_count;
  logic       push;
  result_t    push_data;

  // Accept and classify items; hold up to two ahead of the back end.
  fsp_front u_front (
    .clk(clk), .rst(rst), .req(req), .ctl(ctl), .op(op), .op_valid(op_valid)
  );

  // Carry out items against drive state and the track buffer.
  fsp_exec #(
    .TRACK_BYTES(TRACK_BYTES),
    .MAX_HALF_TRACK(MAX_HALF_TRACK)
  ) u_exec (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .op(op), .op_valid(op_valid), .out_count(out_count),
    .ctl(ctl), .push(push), .push_data(push_data)
  );

  // Buffer results so a stalled sink does not stop the input side until the queue fills.
  fsp_outq u_outq (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .count(out_count), .rsp(rsp)
  );

endmodule

// File: src/fsp_checker.sv
// Port-level checks for the floppy stepper port, bound to the top level.
module fsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        load_request,
  input logic        flush_request,
  input logic        request_drive,
  input logic [5:0]  request_track,
  input logic [11:0] flush_start,
  input logic [11:0] flush_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(flush_count) && $stable(request_track))
    else $error("result dropped or changed while stalled");

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(load_request && flush_request))
    else $error("load and flush raised together");

  a_no_req_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !load_request && !flush_request |-> request_track == 6'd0 && !request_drive)
    else $error("request fields set without a request");

  a_flush_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !flush_request |-> flush_start == 12'd0 && flush_count == 12'd0)
    else $error("flush fields set without a flush");

endmodule

bind floppy_stepper_and_fm_track_port fsp_checker u_fsp_checker (
  .clk(clk), .rst(rst),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .load_request(rsp.load_request), .flush_request(rsp.flush_request),
  .request_drive(rsp.request_drive), .request_track(rsp.request_track),
  .flush_start(rsp.flush_start), .flush_count(rsp.flush_count)
);
